### rtl/fdi_pkg.sv
// Shared constants, types and codes of the fractional delay interpolator.
package fdi_pkg;

	localparam int STORE_DEPTH = 2048;
	localparam int ADDR_W      = $clog2(STORE_DEPTH);
	localparam int LEN_W       = ADDR_W + 1;
	localparam int FRAC_W      = 16;
	localparam int SAMPLE_W    = 24;
	localparam int POS_W       = ADDR_W + FRAC_W;
	localparam int CFG_W       = LEN_W;
	localparam int CIDX_W      = 2;

	// Catmull-Rom working widths (coefficients doubled to stay integer)
	localparam int COEF_W = SAMPLE_W + 4;
	localparam int H_W    = SAMPLE_W + 6;
	localparam int PROD_W = H_W + FRAC_W + 1;
	localparam int RES_W  = SAMPLE_W + 8;

	localparam int SAMPLE_MAX = 2 ** (SAMPLE_W - 1) - 1;
	localparam int SAMPLE_MIN = -(2 ** (SAMPLE_W - 1));

	localparam logic [CIDX_W-1:0] REG_MODE   = 2'd0;
	localparam logic [CIDX_W-1:0] REG_LENGTH = 2'd1;

	typedef enum logic [1:0] {
		MODE_NEAREST,
		MODE_LINEAR,
		MODE_CUBIC,
		MODE_INVALID
	} mode_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_PREP,
		ST_FETCH,
		ST_DRAIN,
		ST_COEF,
		ST_MUL1,
		ST_ACC1,
		ST_MUL2,
		ST_ACC2,
		ST_MUL3,
		ST_FIN
	} ctl_state_t;

	typedef struct packed {
		logic       clear;
		logic       write;
		logic       load;
		logic       prep;
		logic       fetch;
		logic [1:0] idx;
		logic       coef;
		logic       mul;
		logic       acc;
		logic       acc_c2;
		logic       fin;
	} dp_cmd_t;

	typedef struct packed {
		logic  clr_last;
		mode_t mode;
	} dp_stat_t;

endpackage

### rtl/fdi_ram.sv
// Generic single write port, single read port RAM with registered read data.
module fdi_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### rtl/fdi_ctrl.sv
// Controller state machine: store clearing, tap fetch sequence and arithmetic steps.
module fdi_ctrl import fdi_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	input  logic     kind,
	input  dp_stat_t stat,
	output logic     busy,
	output dp_cmd_t  cmd
);

	ctl_state_t state_q, state_d;
	logic [1:0] fetch_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			fetch_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_FETCH) begin
				fetch_q <= fetch_q + 2'd1;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: if (stat.clr_last) state_d = ST_IDLE;
			ST_IDLE:  if (start && kind) state_d = ST_PREP;
			ST_PREP:  state_d = ST_FETCH;
			ST_FETCH: if (&fetch_q) state_d = ST_DRAIN;
			ST_DRAIN: begin
				if (stat.mode == MODE_CUBIC || stat.mode == MODE_LINEAR) begin
					state_d = ST_COEF;
				end else begin
					state_d = ST_FIN;
				end
			end
			ST_COEF:  state_d = (stat.mode == MODE_CUBIC) ? ST_MUL1 : ST_MUL3;
			ST_MUL1:  state_d = ST_ACC1;
			ST_ACC1:  state_d = ST_MUL2;
			ST_MUL2:  state_d = ST_ACC2;
			ST_ACC2:  state_d = ST_MUL3;
			ST_MUL3:  state_d = ST_FIN;
			ST_FIN:   state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd  = '0;
		busy = 1'b1;
		case (state_q)
			ST_CLEAR: cmd.clear = 1'b1;
			ST_IDLE: begin
				busy      = 1'b0;
				cmd.load  = start && kind;
				cmd.write = start && !kind;
			end
			ST_PREP:  cmd.prep = 1'b1;
			ST_FETCH: begin
				cmd.fetch = 1'b1;
				cmd.idx   = fetch_q;
			end
			ST_DRAIN: cmd = '0;
			ST_COEF:  cmd.coef = 1'b1;
			ST_MUL1, ST_MUL2, ST_MUL3: cmd.mul = 1'b1;
			ST_ACC1:  cmd.acc = 1'b1;
			ST_ACC2: begin
				cmd.acc    = 1'b1;
				cmd.acc_c2 = 1'b1;
			end
			ST_FIN:   cmd.fin = 1'b1;
			default:  cmd = '0;
		endcase
	end

endmodule

### rtl/fdi_datapath.sv
// Datapath: config registers, delay store, tap indexing, shared multiplier, rounding, saturation.
module fdi_datapath import fdi_pkg::*; (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [CIDX_W-1:0]          cfg_index,
	input  logic [CFG_W-1:0]           cfg_data,
	input  logic [ADDR_W-1:0]          write_address,
	input  logic signed [SAMPLE_W-1:0] write_sample,
	input  logic [POS_W-1:0]           read_position,
	input  dp_cmd_t                    cmd,
	output dp_stat_t                   stat,
	output logic                       done,
	output logic signed [SAMPLE_W-1:0] read_sample
);

	localparam logic signed [PROD_W:0] RND_CUB = (PROD_W + 1)'(2 ** FRAC_W);
	localparam logic signed [PROD_W:0] RND_LIN = (PROD_W + 1)'(2 ** (FRAC_W - 1));

	logic [1:0]       mode_q;
	logic [LEN_W-1:0] length_q;
	logic [LEN_W-1:0] len;

	logic [ADDR_W-1:0] clr_q;
	logic [ADDR_W-1:0] ip_q, prev_q, nx_q;
	logic [FRAC_W-1:0] f_q;

	logic [LEN_W-1:0]  ip_raw, nx_sum, nx2_sum, ip_sum;
	logic [ADDR_W-1:0] ip_clamp, nx2, raddr;

	logic                ram_we;
	logic [ADDR_W-1:0]   ram_waddr;
	logic [SAMPLE_W-1:0] ram_wdata, ram_rdata;

	logic       rdv_s1;
	logic [1:0] rdi_s1;
	logic signed [SAMPLE_W-1:0] s_q [4];

	logic signed [COEF_W-1:0] e0, e1, e2, e3, c0, c1, c2;
	logic signed [COEF_W-1:0] c1_q, c2_q;
	logic signed [H_W-1:0]    h_q, h_d;
	logic signed [PROD_W-1:0] prod_q, prod_sh;
	logic signed [PROD_W:0]   rsum, rshift;
	logic signed [RES_W-1:0]  res;
	logic signed [SAMPLE_W-1:0] res_sat;

	// effective length: zero reads as one, above depth reads as depth
	always_comb begin
		len = length_q;
		if (length_q == '0) begin
			len = LEN_W'(1);
		end else if (length_q > LEN_W'(STORE_DEPTH)) begin
			len = LEN_W'(STORE_DEPTH);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_LINEAR;
			length_q <= LEN_W'(STORE_DEPTH);
		end else if (cfg_we) begin
			if (cfg_index == REG_MODE) begin
				mode_q <= cfg_data[1:0];
			end else if (cfg_index == REG_LENGTH) begin
				length_q <= cfg_data[LEN_W-1:0];
			end
		end
	end

	assign stat.mode     = mode_t'(mode_q);
	assign stat.clr_last = &clr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.clear) begin
			clr_q <= clr_q + ADDR_W'(1);
		end
	end

	// store write: clearing sweep or write item
	always_comb begin
		ram_we    = cmd.clear || (cmd.write && ({1'b0, write_address} < len));
		ram_waddr = cmd.clear ? clr_q : write_address;
		ram_wdata = cmd.clear ? '0 : write_sample;
	end

	// integer part clamped to length-1, fraction kept
	always_comb begin
		ip_raw   = {1'b0, read_position[POS_W-1:FRAC_W]};
		ip_clamp = (ip_raw >= len) ? ADDR_W'(len - LEN_W'(1)) : ip_raw[ADDR_W-1:0];
		ip_sum   = {1'b0, ip_q} + LEN_W'(1);
		nx_sum   = {1'b0, nx_q} + LEN_W'(1);
		nx2      = (nx_sum == len) ? '0 : nx_sum[ADDR_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			ip_q <= ip_clamp;
			f_q  <= read_position[FRAC_W-1:0];
		end
		if (cmd.prep) begin
			prev_q <= (ip_q == '0) ? ADDR_W'(len - LEN_W'(1)) : ip_q - ADDR_W'(1);
			nx_q   <= (ip_sum == len) ? '0 : ip_sum[ADDR_W-1:0];
		end
	end

	assign nx2_sum = nx_sum;

	always_comb begin
		case (cmd.idx)
			2'd0:    raddr = prev_q;
			2'd1:    raddr = ip_q;
			2'd2:    raddr = nx_q;
			2'd3:    raddr = nx2;
			default: raddr = ip_q;
		endcase
	end

	fdi_ram #(
		.WIDTH(SAMPLE_W),
		.DEPTH(STORE_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(raddr),
		.rdata(ram_rdata)
	);

	// read data lands in the cycle after its address
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rdv_s1 <= 1'b0;
		end else begin
			rdv_s1 <= cmd.fetch && (nx2_sum != '1);
		end
	end

	always_ff @(posedge clk) begin
		rdi_s1 <= cmd.idx;
		if (rdv_s1) begin
			s_q[rdi_s1] <= ram_rdata;
		end
	end

	always_comb begin
		e0 = COEF_W'(s_q[0]);
		e1 = COEF_W'(s_q[1]);
		e2 = COEF_W'(s_q[2]);
		e3 = COEF_W'(s_q[3]);
		c0 = e3 - e0 + (e1 <<< 1) + e1 - (e2 <<< 1) - e2;
		c1 = (e0 <<< 1) - (e1 <<< 2) - e1 + (e2 <<< 2) - e3;
		c2 = e2 - e0;
	end

	assign prod_sh = prod_q >>> FRAC_W;
	assign h_d     = prod_sh[H_W-1:0] + H_W'(cmd.acc_c2 ? c2_q : c1_q);

	always_ff @(posedge clk) begin
		if (cmd.coef) begin
			h_q  <= (stat.mode == MODE_CUBIC) ? H_W'(c0) : H_W'(e2 - e1);
			c1_q <= c1;
			c2_q <= c2;
		end else if (cmd.acc) begin
			h_q <= h_d;
		end
		if (cmd.mul) begin
			prod_q <= h_q * $signed({1'b0, f_q});
		end
	end

	always_comb begin
		if (stat.mode == MODE_CUBIC) begin
			rsum   = (PROD_W + 1)'(prod_q) + RND_CUB;
			rshift = rsum >>> (FRAC_W + 1);
		end else begin
			rsum   = (PROD_W + 1)'(prod_q) + RND_LIN;
			rshift = rsum >>> FRAC_W;
		end
		case (stat.mode)
			MODE_NEAREST: res = f_q[FRAC_W-1] ? RES_W'(s_q[2]) : RES_W'(s_q[1]);
			MODE_LINEAR, MODE_CUBIC: res = RES_W'(s_q[1]) + RES_W'(rshift);
			default:      res = '0;
		endcase
		if (res > RES_W'(SAMPLE_MAX)) begin
			res_sat = SAMPLE_W'(SAMPLE_MAX);
		end else if (res < RES_W'(SAMPLE_MIN)) begin
			res_sat = SAMPLE_W'(SAMPLE_MIN);
		end else begin
			res_sat = res[SAMPLE_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= cmd.fin;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.fin) begin
			read_sample <= res_sat;
		end
	end

endmodule

### rtl/fractional_delay_interpolator_top.sv
// Write item: stored at its accept edge, no result, next item in the following cycle.
// Read item: result strobed on done after prep, four tap reads through the single store
// read port and a drain step; linear and cubic then take coefficients and up to three
// passes through one 30x17 multiplier; nearest and invalid mode skip them. Next item
// accepted with done. Reset clears config to linear, length 2048, then a sweep zeroes the
// store while busy is high. Results are a one-cycle strobe; the receiver cannot stall.
module fractional_delay_interpolator_top import fdi_pkg::*; (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [CIDX_W-1:0]          cfg_index,
	input  logic [CFG_W-1:0]           cfg_data,
	input  logic                       start,
	output logic                       busy,
	input  logic                       kind,
	input  logic [ADDR_W-1:0]          write_address,
	input  logic signed [SAMPLE_W-1:0] write_sample,
	input  logic [POS_W-1:0]           read_position,
	output logic                       done,
	output logic signed [SAMPLE_W-1:0] read_sample
);

	dp_cmd_t  cmd;
	dp_stat_t stat;

	fdi_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.kind  (kind),
		.stat  (stat),
		.busy  (busy),
		.cmd   (cmd)
	);

	fdi_datapath u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.write_address(write_address),
		.write_sample (write_sample),
		.read_position(read_position),
		.cmd          (cmd),
		.stat         (stat),
		.done         (done),
		.read_sample  (read_sample)
	);

endmodule

### rtl/fdi_checker.sv
// Port-level checks of the item sequencing, bound to the top level.
module fdi_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic kind,
	input logic done
);

	// a result only follows a busy read item
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy)) else $error("result without preceding busy item");

	// a write item never produces a result
	a_write_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && !kind) |=> !done) else $error("result after write item");

	// a read item occupies the block
	a_read_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && kind) |=> (busy && !done)) else $error("read item not busy");

	// the result strobe comes when the block is free again
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy) else $error("result while still busy");

endmodule

bind fractional_delay_interpolator_top fdi_checker u_fdi_checker (
	.clk   (clk),
	.arst_n(arst_n),
	.start (start),
	.busy  (busy),
	.kind  (kind),
	.done  (done)
);
